### rtl/core/pac_pkg.sv
package pac_pkg;

  // Default configuration
  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 16;

  // Fixed field widths
  localparam int COORD_W = 16;
  localparam int OUT_W   = 16;
  localparam int AREA_W  = 40;
  localparam int WSUM_W  = 58;
  localparam int STAT_W  = 2;

  // Datapath widths for the fan arithmetic
  localparam int DIFF_W  = COORD_W + 1;        // vertex difference
  localparam int PROD_W  = 2 * DIFF_W;         // one cross term
  localparam int CROSS_W = PROD_W + 1;         // doubled triangle area
  localparam int CSUM_W  = COORD_W + 2;        // sum of three coordinates
  localparam int WPRD_W  = CROSS_W + CSUM_W;   // weighted area of one triangle
  localparam int DEN_W   = AREA_W + 2;         // three times the area sum

  // Divider widths: quotient keeps two bits beyond the output width
  localparam int QUO_W   = OUT_W + 2;
  localparam int REM_W   = DEN_W + QUO_W - 1;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ZERO     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_TOO_MANY = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CROSS,
    S_WMUL,
    S_WACC,
    S_FIN,
    S_DIVX_GO,
    S_DIVX_WAIT,
    S_DIVY_GO,
    S_DIVY_WAIT,
    S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // vertex transaction taken this cycle
    logic mul;        // form the two cross terms
    logic sub;        // subtract cross terms
    logic wmul;       // weight the area, accumulate area
    logic wacc;       // accumulate weighted sums
    logic prep;       // register the divisor
    logic div_start;  // launch a division
    logic div_sel;    // 0: x sum, 1: y sum
    logic cap_x;      // store x quotient
    logic cap_y;      // store y quotient
    logic out_load;   // load output register and clear accumulators
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic closes_tri; // next vertex closes a triangle
    logic need_div;   // polygon valid with non-zero area
    logic div_done;   // quotient ready
    logic out_full;   // output register still occupied
  } sts_t;

endpackage

### rtl/core/pac_div.sv
// Signed restoring divider, one quotient bit per cycle, result saturated to OUT_W bits.
module pac_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [pac_pkg::WSUM_W-1:0]    num,
  input  logic signed [pac_pkg::DEN_W-1:0]     den,
  output logic                                 done,
  output logic signed [pac_pkg::OUT_W-1:0]     quo
);

  localparam int QW   = pac_pkg::QUO_W;
  localparam int RW   = pac_pkg::REM_W;
  localparam int NW   = pac_pkg::WSUM_W;
  localparam int DW   = pac_pkg::DEN_W;
  localparam int OW   = pac_pkg::OUT_W;
  localparam int CW   = $clog2(QW);
  localparam logic [QW-1:0] POS_MAX = QW'(2 ** (OW - 1) - 1);
  localparam logic [QW-1:0] NEG_MAX = QW'(2 ** (OW - 1));

  logic          busy;
  logic [CW-1:0] step;
  logic [RW-1:0] rem;
  logic [RW-1:0] dsh;
  logic [QW-1:0] q;
  logic          neg;
  logic          dzero;

  logic [NW-1:0] n_abs;
  logic [DW-1:0] d_abs;
  logic          fits;

  // Magnitudes of the operands
  assign n_abs = num[NW-1] ? NW'(-num) : NW'(num);
  assign d_abs = den[DW-1] ? DW'(-den) : DW'(den);
  assign fits  = rem >= dsh;

  // Iteration: the divisor shift walks down one place a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= CW'(QW - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // Remainder and quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= RW'(n_abs);
      dsh   <= {d_abs, {(QW - 1){1'b0}}};
      q     <= '0;
      neg   <= num[NW-1] ^ den[DW-1];
      dzero <= (d_abs == '0);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        q   <= {q[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  // Sign and saturation, truncation toward zero
  always_comb begin
    if (dzero) begin
      quo = '0;
    end else if (neg) begin
      quo = (q > NEG_MAX) ? OW'(NEG_MAX) : OW'(-q);
    end else begin
      quo = (q > POS_MAX) ? OW'(POS_MAX) : OW'(q);
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("divider restarted while busy");

endmodule

### rtl/core/pac_datapath.sv
// Fan accumulation, divisor preparation and the output register.
module pac_datapath #(
  parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pac_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pac_pkg::cmd_t                         cmd,
  output pac_pkg::sts_t                         sts,
  input  logic signed [pac_pkg::COORD_W-1:0]    vertex_x,
  input  logic signed [pac_pkg::COORD_W-1:0]    vertex_y,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [71:0]                           m_tdata,
  output logic [pac_pkg::STAT_W-1:0]            m_tuser
);

  localparam int CW    = pac_pkg::COORD_W;
  localparam int SH    = CW - COORD_WIDTH;
  localparam int CNT_W = $clog2(MAX_VERTICES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_VERTICES + 1);

  // Fan state
  logic signed [CW-1:0] anchor_x, anchor_y, previous_x, previous_y;
  logic [CNT_W-1:0]     vertex_count;
  logic signed [pac_pkg::AREA_W-1:0] area_sum;
  logic signed [pac_pkg::WSUM_W-1:0] weighted_x_sum, weighted_y_sum;

  // Pipeline registers for one triangle
  logic signed [pac_pkg::DIFF_W-1:0]  dx1, dy1, dx2, dy2;
  logic signed [pac_pkg::CSUM_W-1:0]  sx, sy;
  logic signed [pac_pkg::PROD_W-1:0]  p1, p2;
  logic signed [pac_pkg::CROSS_W-1:0] cr;
  logic signed [pac_pkg::WPRD_W-1:0]  wx, wy;

  // Finish path
  logic signed [pac_pkg::DEN_W-1:0]   den;
  logic signed [pac_pkg::OUT_W-1:0]   cx, cy;
  logic                               div_done;
  logic signed [pac_pkg::OUT_W-1:0]   div_quo;
  logic [pac_pkg::STAT_W-1:0]         status;
  logic                               valid_poly;
  logic                               out_full;

  logic signed [CW-1:0] xs_up, ys_up, xs, ys;

  // Keep the low COORD_WIDTH bits, sign-extended
  assign xs_up = vertex_x <<< SH;
  assign ys_up = vertex_y <<< SH;
  assign xs    = xs_up >>> SH;
  assign ys    = ys_up >>> SH;

  // Vertex capture and count
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      anchor_x     <= '0;
      anchor_y     <= '0;
      previous_x   <= '0;
      previous_y   <= '0;
    end else if (cmd.out_load) begin
      vertex_count <= '0;
      anchor_x     <= '0;
      anchor_y     <= '0;
      previous_x   <= '0;
      previous_y   <= '0;
    end else if (cmd.accept) begin
      if (vertex_count >= CNT_MAX) begin
        vertex_count <= CNT_OVER;
      end else begin
        if (vertex_count == '0) begin
          anchor_x <= xs;
          anchor_y <= ys;
        end
        previous_x   <= xs;
        previous_y   <= ys;
        vertex_count <= vertex_count + 1'b1;
      end
    end
  end

  // Triangle operands from the incoming vertex, the arithmetic stages, the divisor and the quotients
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dx1 <= pac_pkg::DIFF_W'(previous_x) - pac_pkg::DIFF_W'(anchor_x);
      dy1 <= pac_pkg::DIFF_W'(previous_y) - pac_pkg::DIFF_W'(anchor_y);
      dx2 <= pac_pkg::DIFF_W'(xs) - pac_pkg::DIFF_W'(anchor_x);
      dy2 <= pac_pkg::DIFF_W'(ys) - pac_pkg::DIFF_W'(anchor_y);
      sx  <= pac_pkg::CSUM_W'(anchor_x) + pac_pkg::CSUM_W'(previous_x)
           + pac_pkg::CSUM_W'(xs);
      sy  <= pac_pkg::CSUM_W'(anchor_y) + pac_pkg::CSUM_W'(previous_y)
           + pac_pkg::CSUM_W'(ys);
    end
    if (cmd.mul) begin
      p1 <= dx1 * dy2;
      p2 <= dy1 * dx2;
    end
    if (cmd.sub) begin
      cr <= pac_pkg::CROSS_W'(p1) - pac_pkg::CROSS_W'(p2);
    end
    if (cmd.wmul) begin
      wx <= cr * sx;
      wy <= cr * sy;
    end
    if (cmd.prep) begin
      den <= pac_pkg::DEN_W'(area_sum) + (pac_pkg::DEN_W'(area_sum) <<< 1);
    end
    if (div_done && cmd.cap_x) begin
      cx <= div_quo;
    end
    if (div_done && cmd.cap_y) begin
      cy <= div_quo;
    end
  end

  // Accumulators, wrapping
  always_ff @(posedge clk) begin
    if (rst) begin
      area_sum       <= '0;
      weighted_x_sum <= '0;
      weighted_y_sum <= '0;
    end else if (cmd.out_load) begin
      area_sum       <= '0;
      weighted_x_sum <= '0;
      weighted_y_sum <= '0;
    end else begin
      if (cmd.wmul) begin
        area_sum <= area_sum + pac_pkg::AREA_W'(cr);
      end
      if (cmd.wacc) begin
        weighted_x_sum <= weighted_x_sum + pac_pkg::WSUM_W'(wx);
        weighted_y_sum <= weighted_y_sum + pac_pkg::WSUM_W'(wy);
      end
    end
  end

  // Shared divider for both axes
  pac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_sel ? weighted_y_sum : weighted_x_sum),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Polygon status
  always_comb begin
    if (vertex_count > CNT_MAX) begin
      status = pac_pkg::STATUS_TOO_MANY;
    end else if (area_sum == '0) begin
      status = pac_pkg::STATUS_ZERO;
    end else begin
      status = pac_pkg::STATUS_OK;
    end
  end
  assign valid_poly = (status == pac_pkg::STATUS_OK);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.out_load) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= valid_poly ? {area_sum, cy, cx} : '0;
      m_tuser <= status;
    end
  end

  assign m_tvalid = out_full;

  assign sts.closes_tri = (vertex_count >= CNT_W'(2)) && (vertex_count < CNT_MAX);
  assign sts.need_div   = valid_poly;
  assign sts.div_done   = div_done;
  assign sts.out_full   = out_full;

  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> !out_full)
    else $error("output register overwritten");
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> vertex_count == '0)
    else $error("fan state not cleared after result");
  assert property (@(posedge clk) disable iff (rst) vertex_count <= CNT_OVER)
    else $error("vertex count beyond saturation");
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser == pac_pkg::STATUS_OK) |-> m_tdata[71:32] != '0)
    else $error("ok status with zero area");

endmodule

### rtl/core/pac_ctrl.sv
// Sequencer: vertex arithmetic, two divisions if needed, then the result load.
module pac_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic          s_tlast,
  output pac_pkg::cmd_t cmd,
  input  pac_pkg::sts_t sts
);

  pac_pkg::state_t state, state_next;
  logic            last_flag;

  // State and final-vertex flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pac_pkg::S_IDLE;
      last_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        last_flag <= s_tlast;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pac_pkg::S_IDLE: begin
        if (s_tvalid) begin
          if (sts.closes_tri) begin
            state_next = pac_pkg::S_MUL;
          end else if (s_tlast) begin
            state_next = pac_pkg::S_FIN;
          end
        end
      end
      pac_pkg::S_MUL:   state_next = pac_pkg::S_CROSS;
      pac_pkg::S_CROSS: state_next = pac_pkg::S_WMUL;
      pac_pkg::S_WMUL:  state_next = pac_pkg::S_WACC;
      pac_pkg::S_WACC:  state_next = last_flag ? pac_pkg::S_FIN : pac_pkg::S_IDLE;
      pac_pkg::S_FIN:   state_next = sts.need_div ? pac_pkg::S_DIVX_GO : pac_pkg::S_OUT;
      pac_pkg::S_DIVX_GO: state_next = pac_pkg::S_DIVX_WAIT;
      pac_pkg::S_DIVX_WAIT: begin
        if (sts.div_done) begin
          state_next = pac_pkg::S_DIVY_GO;
        end
      end
      pac_pkg::S_DIVY_GO: state_next = pac_pkg::S_DIVY_WAIT;
      pac_pkg::S_DIVY_WAIT: begin
        if (sts.div_done) begin
          state_next = pac_pkg::S_OUT;
        end
      end
      pac_pkg::S_OUT: begin
        if (!sts.out_full) begin
          state_next = pac_pkg::S_IDLE;
        end
      end
      default: state_next = pac_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      pac_pkg::S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      pac_pkg::S_MUL:   cmd.mul   = 1'b1;
      pac_pkg::S_CROSS: cmd.sub   = 1'b1;
      pac_pkg::S_WMUL:  cmd.wmul  = 1'b1;
      pac_pkg::S_WACC:  cmd.wacc  = 1'b1;
      pac_pkg::S_FIN:   cmd.prep  = 1'b1;
      pac_pkg::S_DIVX_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b0;
      end
      pac_pkg::S_DIVX_WAIT: cmd.cap_x = 1'b1;
      pac_pkg::S_DIVY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      pac_pkg::S_DIVY_WAIT: cmd.cap_y = 1'b1;
      pac_pkg::S_OUT:   cmd.out_load = !sts.out_full;
      default: cmd = '0;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
      (state == pac_pkg::S_FIN && !sts.need_div) |=> state == pac_pkg::S_OUT)
    else $error("degenerate polygon entered division");
  assert property (@(posedge clk) disable iff (rst)
      (cmd.accept && !sts.closes_tri && !s_tlast) |=> state == pac_pkg::S_IDLE)
    else $error("non-triangle vertex did not return to idle");
  assert property (@(posedge clk) disable iff (rst)
      cmd.out_load |=> state == pac_pkg::S_IDLE)
    else $error("result load did not end the polygon");

endmodule

### rtl/core/polygon_area_centroid_top.sv
// Polygon area and centroid by triangle fan.
// Input channel s_*: one vertex per transaction, s_tlast marks the final vertex.
// The first vertex is the fan anchor; each vertex from the third to the MAX_VERTICES-th
// adds one triangle's doubled area and area-weighted coordinate sums.
// Output channel m_*: one transaction per polygon with the centroid, the doubled
// signed area and a status code in m_tuser (ok, zero area, too many vertices).
// A vertex that closes no triangle is taken in the idle state; one that closes a
// triangle then holds off the input through the multiply, subtract, weight and
// accumulate states. The final vertex adds the finish: the divisor is registered,
// then two divisions run on one shared restoring divider, then the output load.
// A zero-area or over-long polygon skips the divisions and goes straight to the
// output load.
// The output register decouples the two sides: vertices of the next polygon are
// taken while a result waits; only a second result stalls on a full register.
// Reset (rst, synchronous) clears the fan state, the sequencer and m_tvalid.
module polygon_area_centroid_top #(
  parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pac_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] vertex_x, [31:16] vertex_y
  input  logic        s_tlast,   // last_vertex
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [15:0] centroid_x, [31:16] centroid_y, [71:32] double_area
  output logic [1:0]  m_tuser    // [1:0] status
);

  pac_pkg::cmd_t cmd;
  pac_pkg::sts_t sts;

  pac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .sts      (sts)
  );

  pac_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .vertex_x (s_tdata[15:0]),
    .vertex_y (s_tdata[31:16]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### tb/sv/polygon_area_centroid_top_test.sv
module polygon_area_centroid_top_test;

  localparam int MAX_VERTS       = pac_pkg::MAX_VERTICES_DEF;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int ITEMS_PER_PHASE = 340;

  // How the coordinates of one polygon are drawn
  typedef enum int {
    STYLE_FULL,
    STYLE_SMALL,
    STYLE_EXTREME,
    STYLE_GRID,
    STYLE_MIXED
  } coord_style_t;

  typedef struct packed {
    logic [pac_pkg::COORD_W-1:0] x;
    logic [pac_pkg::COORD_W-1:0] y;
    logic                        last;
  } vertex_t;

  typedef struct packed {
    logic [pac_pkg::OUT_W-1:0]  cx;
    logic [pac_pkg::OUT_W-1:0]  cy;
    logic [pac_pkg::AREA_W-1:0] area;
    logic [pac_pkg::STAT_W-1:0] status;
  } poly_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;

  vertex_t      vertex_q[$];
  poly_result_t polygon_result_q[$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_go       = 1'b0;
  logic hold_done     = 1'b0;
  int   hold_cnt      = 0;
  int   fail_count    = 0;
  int   stall_cnt     = 0;

  // Fan state of the predictor
  logic signed [pac_pkg::COORD_W-1:0] fan_ax   = '0;
  logic signed [pac_pkg::COORD_W-1:0] fan_ay   = '0;
  logic signed [pac_pkg::COORD_W-1:0] fan_px   = '0;
  logic signed [pac_pkg::COORD_W-1:0] fan_py   = '0;
  int                                 fan_count = 0;
  logic signed [pac_pkg::AREA_W-1:0]  area_acc = '0;
  logic signed [pac_pkg::WSUM_W-1:0]  wx_acc   = '0;
  logic signed [pac_pkg::WSUM_W-1:0]  wy_acc   = '0;

  always #6 clk = ~clk;

  polygon_area_centroid_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] vertex_x, [31:16] vertex_y
    .s_tlast  (s_tlast),   // last_vertex
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [15:0] centroid_x, [31:16] centroid_y, [71:32] double_area
    .m_tuser  (m_tuser)    // [1:0] status
  );

  // Weighted sum over three times the area, truncated toward zero, saturated
  function automatic logic [pac_pkg::OUT_W-1:0] fan_centroid(input longint wsum,
                                                             input longint den);
    longint unsigned n, d, q, t;
    logic            neg;
    n   = (wsum < 0) ? longint'(-wsum) : longint'(wsum);
    d   = (den < 0) ? longint'(-den) : longint'(den);
    neg = (wsum < 0) != (den < 0);
    if (d == 0) return '0;
    q = n / d;
    if (neg) begin
      if (q > 64'd32768) return 16'h8000;
      t = -q;
      return t[pac_pkg::OUT_W-1:0];
    end
    if (q > 64'd32767) return 16'h7fff;
    return q[pac_pkg::OUT_W-1:0];
  endfunction

  // Fold one vertex into the fan; on the last vertex queue the polygon's result
  function automatic void fan_accumulate(input logic [pac_pkg::COORD_W-1:0] vx, vy,
                                         input logic last);
    longint       x, y, ax, ay, px, py, cr, ar;
    poly_result_t res;
    x = longint'($signed(vx));
    y = longint'($signed(vy));
    if (fan_count >= MAX_VERTS) begin
      fan_count = MAX_VERTS + 1;
    end else begin
      if (fan_count == 0) begin
        fan_ax = vx;
        fan_ay = vy;
      end else if (fan_count >= 2) begin
        ax = longint'(fan_ax);
        ay = longint'(fan_ay);
        px = longint'(fan_px);
        py = longint'(fan_py);
        cr = (px - ax) * (y - ay) - (py - ay) * (x - ax);
        area_acc = pac_pkg::AREA_W'(area_acc + cr);
        wx_acc   = pac_pkg::WSUM_W'(wx_acc + cr * (ax + px + x));
        wy_acc   = pac_pkg::WSUM_W'(wy_acc + cr * (ay + py + y));
      end
      fan_px = vx;
      fan_py = vy;
      fan_count++;
    end
    if (last) begin
      res = '0;
      if (fan_count > MAX_VERTS) begin
        res.status = pac_pkg::STATUS_TOO_MANY;
      end else if (area_acc == 0) begin
        res.status = pac_pkg::STATUS_ZERO;
      end else begin
        ar         = longint'(area_acc);
        res.status = pac_pkg::STATUS_OK;
        res.area   = area_acc;
        res.cx     = fan_centroid(longint'(wx_acc), ar * 3);
        res.cy     = fan_centroid(longint'(wy_acc), ar * 3);
      end
      polygon_result_q = {polygon_result_q, res};
      fan_count = 0;
      fan_ax    = '0;
      fan_ay    = '0;
      fan_px    = '0;
      fan_py    = '0;
      area_acc  = '0;
      wx_acc    = '0;
      wy_acc    = '0;
    end
  endfunction

  function automatic void check_field(input string name, input longint expv, actv);
    if (expv != actv) begin
      $error("%s: expected %0d, actual %0d", name, expv, actv);
      fail_count++;
    end
  endfunction

  function automatic void push_vertex(input logic [pac_pkg::COORD_W-1:0] x, y,
                                      input logic last);
    vertex_t v;
    v = '{x, y, last};
    vertex_q = {vertex_q, v};
  endfunction

  function automatic logic [pac_pkg::COORD_W-1:0] rand_coord(input coord_style_t style);
    logic [31:0] r;
    int          t;
    r = $urandom;
    case (style)
      STYLE_SMALL: begin
        return {{5{r[11]}}, r[10:0]};
      end
      STYLE_EXTREME: begin
        case (r[1:0])
          2'd0:    return 16'h8000;
          2'd1:    return 16'h7fff;
          2'd2:    return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      STYLE_GRID: begin
        // coarse integer grid: many collinear and zero-area fans
        t = $urandom_range(8, 0);
        t = (t - 4) * 256;
        return t[pac_pkg::COORD_W-1:0];
      end
      default: begin
        return r[pac_pkg::COORD_W-1:0];
      end
    endcase
  endfunction

  // Whole polygons with random size and content, until about n vertices are queued
  task automatic queue_random_polygons(input int n);
    int           added, nverts, r;
    coord_style_t style, vstyle;
    added = 0;
    while (added < n) begin
      r = $urandom_range(99, 0);
      if (r < 5)       nverts = $urandom_range(2, 1);
      else if (r < 80) nverts = $urandom_range(8, 3);
      else if (r < 90) nverts = $urandom_range(14, 9);
      else             nverts = $urandom_range(20, 15);
      r = $urandom_range(99, 0);
      if (r < 35)      style = STYLE_FULL;
      else if (r < 65) style = STYLE_SMALL;
      else if (r < 75) style = STYLE_EXTREME;
      else if (r < 85) style = STYLE_GRID;
      else             style = STYLE_MIXED;
      for (int i = 0; i < nverts; i++) begin
        vstyle = (style == STYLE_MIXED) ? coord_style_t'($urandom_range(3, 0)) : style;
        push_vertex(rand_coord(vstyle), rand_coord(vstyle), i == nverts - 1);
      end
      added += nverts;
    end
  endtask

  task automatic wait_drained();
    while (vertex_q.size() != 0 || s_tvalid || polygon_result_q.size() != 0)
      @(negedge clk);
  endtask

  // Vertex driver: predict on each accepted transaction, then offer the next vertex
  always @(posedge clk) begin : vertex_driver
    vertex_t v;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        fan_accumulate(s_tdata[15:0], s_tdata[31:16], s_tlast);
      if (!s_tvalid || s_tready) begin
        if (vertex_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          v = vertex_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {v.y, v.x};
          s_tlast  <= v.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest prediction, drive back-pressure
  always @(posedge clk) begin : result_monitor
    poly_result_t exp_res;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (polygon_result_q.size() == 0) begin
          $error("result transaction with no polygon outstanding");
          fail_count++;
        end else begin
          exp_res = polygon_result_q.pop_front();
          check_field("centroid_x", longint'($signed(exp_res.cx)),
                      longint'($signed(m_tdata[15:0])));
          check_field("centroid_y", longint'($signed(exp_res.cy)),
                      longint'($signed(m_tdata[31:16])));
          check_field("double_area", longint'($signed(exp_res.area)),
                      longint'($signed(m_tdata[71:32])));
          check_field("status", longint'(exp_res.status), longint'(m_tuser));
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_go && !hold_done) begin
        m_tready <= 1'b0;
        if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
        hold_cnt <= hold_cnt + 1;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt == STALL_LIMIT) begin
      $display("polygon_area_centroid_top: mismatch");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 54;

    // lone vertex: no triangle, zero area
    push_vertex(16'h0100, 16'hff00, 1'b1);
    // collinear triangle: zero area
    push_vertex(16'h0000, 16'h0000, 1'b0);
    push_vertex(16'h0100, 16'h0100, 1'b0);
    push_vertex(16'h0200, 16'h0200, 1'b1);
    // extreme corners, anticlockwise
    push_vertex(16'h8000, 16'h8000, 1'b0);
    push_vertex(16'h7fff, 16'h8000, 1'b0);
    push_vertex(16'h8000, 16'h7fff, 1'b1);
    // extreme corners, clockwise
    push_vertex(16'h7fff, 16'h7fff, 1'b0);
    push_vertex(16'h7fff, 16'h8000, 1'b0);
    push_vertex(16'h8000, 16'h7fff, 1'b1);
    // one vertex over the limit
    for (int i = 0; i <= MAX_VERTS; i++)
      push_vertex(rand_coord(STYLE_FULL), rand_coord(STYLE_FULL), i == MAX_VERTS);

    queue_random_polygons(ITEMS_PER_PHASE);
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 29;
    queue_random_polygons(ITEMS_PER_PHASE);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_polygons(ITEMS_PER_PHASE);
    hold_go = 1'b1;
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && polygon_result_q.size() == 0) begin
      $display("polygon_area_centroid_top: match");
    end else begin
      $display("polygon_area_centroid_top: mismatch");
    end
    $finish;
  end

endmodule
